FILE: rtl/wfr_pkg.sv
package wfr_pkg;

    localparam int DEPTH_BYTES_DEF = 32;
    localparam int BITS_PER_BYTE   = 8;
    localparam int RESULT_CAP      = 32;

    localparam int FUNC_W    = 2;
    localparam int MAXB_W    = 6;
    localparam int IDX_W     = 5;
    localparam int BC_W      = 9;
    localparam int TIMEOUT_W = 24;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd50000;

    typedef enum logic [FUNC_W-1:0] {
        FN_D0   = 2'd0,
        FN_D1   = 2'd1,
        FN_TICK = 2'd2,
        FN_READ = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic take_bit;
        logic bit_val;
        logic tick;
        logic start_read;
        logic load_single;
        logic issue;
        logic load_out;
        logic clear_frame;
    } cmd_t;

    typedef struct packed {
        logic can_load;
        logic complete;
        logic n_zero;
        logic more;
        logic b_valid;
        logic b_last;
    } status_t;

endpackage

FILE: rtl/wfr_ram.sv
module wfr_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 32,
        parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic             re,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/wfr_ctrl.sv
module wfr_ctrl
    import wfr_pkg::*;
    (
        input  logic              clk,
        input  logic              rst_n,
        input  logic              in_valid,
        input  logic [FUNC_W-1:0] func,
        input  status_t           status,
        output cmd_t              cmd,
        output logic              in_stall
    );

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = (func_t'(func) == FN_READ) && !status.can_load;
                if (in_valid && !in_stall)
                begin
                    case (func_t'(func))
                        FN_D0:
                        begin
                            cmd.take_bit = 1'b1;
                        end
                        FN_D1:
                        begin
                            cmd.take_bit = 1'b1;
                            cmd.bit_val  = 1'b1;
                        end
                        FN_TICK:
                        begin
                            cmd.tick = 1'b1;
                        end
                        FN_READ:
                        begin
                            if (status.complete && !status.n_zero)
                            begin
                                cmd.start_read = 1'b1;
                                state_next     = ST_STREAM;
                            end
                            else
                            begin
                                cmd.load_single = 1'b1;
                                cmd.clear_frame = status.complete;
                            end
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            ST_STREAM:
            begin
                cmd.issue    = status.more && (!status.b_valid || status.can_load);
                cmd.load_out = status.b_valid && status.can_load;
                if (cmd.load_out && status.b_last)
                begin
                    cmd.clear_frame = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/wfr_datapath.sv
module wfr_datapath
    import wfr_pkg::*;
    #(
        parameter int DEPTH_BYTES = DEPTH_BYTES_DEF
    )
    (
        input  logic                 clk,
        input  logic                 rst_n,
        input  logic                 cfg_wr_en,
        input  logic [TIMEOUT_W-1:0] cfg_wr_data,
        input  logic [MAXB_W-1:0]    max_bytes,
        input  cmd_t                 cmd,
        output status_t              status,
        input  logic                 out_stall,
        output logic                 out_valid,
        output logic [7:0]           data_byte,
        output logic [IDX_W-1:0]     byte_index,
        output logic [BC_W-1:0]      bit_count,
        output logic                 data_valid,
        output logic                 last
    );

    localparam int CNT_W = $clog2(DEPTH_BYTES * BITS_PER_BYTE + 1);
    localparam int BSH   = $clog2(BITS_PER_BYTE);
    localparam int AW    = (DEPTH_BYTES > 1) ? $clog2(DEPTH_BYTES) : 1;
    localparam int CAP   = (DEPTH_BYTES < RESULT_CAP) ? DEPTH_BYTES : RESULT_CAP;
    localparam int KW    = MAXB_W;

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [TIMEOUT_W-1:0] idle_reg;
    logic [TIMEOUT_W-1:0] idle_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [7:0]           cur_reg;
    logic [7:0]           cur_next;
    logic [KW-1:0]        n_reg;
    logic [KW-1:0]        n_next;
    logic [KW-1:0]        k_reg;
    logic [KW-1:0]        k_next;
    logic                 b_valid_reg;
    logic                 b_valid_next;
    logic [IDX_W-1:0]     b_idx_reg;
    logic [IDX_W-1:0]     b_idx_next;
    logic                 b_cur_reg;
    logic                 b_cur_next;
    logic                 b_last_reg;
    logic                 b_last_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           data_byte_reg;
    logic [7:0]           data_byte_next;
    logic [IDX_W-1:0]     byte_index_reg;
    logic [IDX_W-1:0]     byte_index_next;
    logic [BC_W-1:0]      bit_count_reg;
    logic [BC_W-1:0]      bit_count_next;
    logic                 data_valid_reg;
    logic                 data_valid_next;
    logic                 last_reg;
    logic                 last_next;

    logic [CNT_W-BSH-1:0] wr_pos;
    logic [31:0]          n_wide;
    logic [KW-1:0]        n_calc;
    logic [AW+KW-1:0]     k_ext;
    logic [7:0]           shifted;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [7:0]           ram_rdata;
    logic                 can_load;

    assign wr_pos    = count_reg[CNT_W-1:BSH];
    assign shifted   = {cur_reg[6:0], cmd.bit_val};
    assign ram_waddr = wr_pos[AW-1:0];
    assign k_ext     = {{AW{1'b0}}, k_reg};
    assign can_load  = !out_valid_reg || !out_stall;

    always_comb
    begin
        n_wide = 32'(wr_pos) + 32'd1;
        if (n_wide > 32'(max_bytes))
        begin
            n_wide = 32'(max_bytes);
        end
        if (n_wide > 32'(CAP))
        begin
            n_wide = 32'(CAP);
        end
        n_calc = n_wide[KW-1:0];
    end

    always_comb
    begin
        status.can_load = can_load;
        status.complete = (count_reg != '0) && (idle_reg > timeout_reg);
        status.n_zero   = (n_calc == '0);
        status.more     = (k_reg < n_reg);
        status.b_valid  = b_valid_reg;
        status.b_last   = b_last_reg;
    end

    always_comb
    begin
        idle_next  = idle_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        ram_we     = 1'b0;
        if (cmd.take_bit)
        begin
            idle_next = '0;
            if (32'(wr_pos) < 32'(DEPTH_BYTES))
            begin
                count_next = CNT_W'(count_reg + 1'b1);
                cur_next   = shifted;
                if (count_reg[BSH-1:0] == '1)
                begin
                    ram_we   = 1'b1;
                    cur_next = '0;
                end
            end
        end
        if (cmd.tick && (idle_reg != '1))
        begin
            idle_next = TIMEOUT_W'(idle_reg + 1'b1);
        end
        if (cmd.clear_frame)
        begin
            count_next = '0;
            cur_next   = '0;
        end
    end

    always_comb
    begin
        n_next       = n_reg;
        k_next       = k_reg;
        b_valid_next = b_valid_reg;
        b_idx_next   = b_idx_reg;
        b_cur_next   = b_cur_reg;
        b_last_next  = b_last_reg;
        if (cmd.start_read)
        begin
            n_next = n_calc;
            k_next = '0;
        end
        if (cmd.load_out)
        begin
            b_valid_next = 1'b0;
        end
        if (cmd.issue)
        begin
            b_valid_next = 1'b1;
            b_idx_next   = IDX_W'(k_reg);
            b_cur_next   = (32'(k_reg) == 32'(wr_pos));
            b_last_next  = (KW'(k_reg + 1'b1) == n_reg);
            k_next       = KW'(k_reg + 1'b1);
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        data_byte_next  = data_byte_reg;
        byte_index_next = byte_index_reg;
        bit_count_next  = bit_count_reg;
        data_valid_next = data_valid_reg;
        last_next       = last_reg;
        if (cmd.load_single)
        begin
            out_valid_next  = 1'b1;
            data_byte_next  = '0;
            byte_index_next = '0;
            bit_count_next  = status.complete ? BC_W'(count_reg) : '0;
            data_valid_next = 1'b0;
            last_next       = 1'b1;
        end
        else if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            data_byte_next  = b_cur_reg ? cur_reg : ram_rdata;
            byte_index_next = b_idx_reg;
            bit_count_next  = BC_W'(count_reg);
            data_valid_next = 1'b1;
            last_next       = b_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            idle_reg      <= '0;
            count_reg     <= '0;
            cur_reg       <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            idle_reg      <= idle_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_idx_reg      <= b_idx_next;
        b_cur_reg      <= b_cur_next;
        b_last_reg     <= b_last_next;
        data_byte_reg  <= data_byte_next;
        byte_index_reg <= byte_index_next;
        bit_count_reg  <= bit_count_next;
        data_valid_reg <= data_valid_next;
        last_reg       <= last_next;
    end

    wfr_ram
        #(
            .WIDTH (8),
            .DEPTH (DEPTH_BYTES),
            .AW    (AW)
        )
        u_buf
        (
            .clk   (clk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (shifted),
            .re    (cmd.issue),
            .raddr (k_ext[AW-1:0]),
            .rdata (ram_rdata)
        );

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign bit_count  = bit_count_reg;
    assign data_valid = data_valid_reg;
    assign last       = last_reg;

endmodule

FILE: rtl/wiegand_frame_receiver_unit.sv
// Wiegand frame receiver. Each D0/D1 pulse item shifts one bit into the frame
// buffer and each tick item ages the idle counter; both never stall while no
// read is in progress. A frame is complete once it holds at least one bit and
// more than timeout_ticks ticks have passed since its last pulse. A read item
// on a complete frame streams min(bits/8+1, max_bytes, DEPTH_BYTES, 32) bytes,
// one per cycle while out_stall is low, through the buffer RAM's registered
// read port and the output register, then clears the frame; any other read
// returns a single item with last set. Input is stalled for the length of the
// stream and whenever a read finds the output register occupied and stalled.
module wiegand_frame_receiver_unit
    import wfr_pkg::*;
    #(
        parameter int DEPTH_BYTES = DEPTH_BYTES_DEF
    )
    (
        input  logic                 clk,
        input  logic                 rst_n,
        input  logic                 cfg_wr_en,
        input  logic [TIMEOUT_W-1:0] cfg_wr_data,
        input  logic                 in_valid,
        output logic                 in_stall,
        input  logic [FUNC_W-1:0]    func,
        input  logic [MAXB_W-1:0]    max_bytes,
        output logic                 out_valid,
        input  logic                 out_stall,
        output logic [7:0]           data_byte,
        output logic [IDX_W-1:0]     byte_index,
        output logic [BC_W-1:0]      bit_count,
        output logic                 data_valid,
        output logic                 last
    );

    cmd_t    cmd;
    status_t status;

    wfr_ctrl u_ctrl
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (in_valid),
            .func     (func),
            .status   (status),
            .cmd      (cmd),
            .in_stall (in_stall)
        );

    wfr_datapath
        #(
            .DEPTH_BYTES (DEPTH_BYTES)
        )
        u_datapath
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cfg_wr_en   (cfg_wr_en),
            .cfg_wr_data (cfg_wr_data),
            .max_bytes   (max_bytes),
            .cmd         (cmd),
            .status      (status),
            .out_stall   (out_stall),
            .out_valid   (out_valid),
            .data_byte   (data_byte),
            .byte_index  (byte_index),
            .bit_count   (bit_count),
            .data_valid  (data_valid),
            .last        (last)
        );

endmodule

FILE: bench/testbench.sv
module testbench;
    import wfr_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [7:0]       dbyte;
        logic [IDX_W-1:0] idx;
        logic [BC_W-1:0]  bits;
        logic             dv;
        logic             last;
    } out_rec_t;

    typedef struct packed {
        func_t             f;
        logic [MAXB_W-1:0] mb;
        logic              typed;
        out_rec_t          exp;
    } dir_row_t;

    localparam out_rec_t NO_FRAME = '{8'd0, 5'd0, 9'd0, 1'b0, 1'b1};

    localparam dir_row_t PLAN [24] = '{
        '{FN_READ, 6'd0,  1'b1, NO_FRAME},
        '{FN_D1,   6'd0,  1'b0, NO_FRAME},
        '{FN_D0,   6'd63, 1'b0, NO_FRAME},
        '{FN_D1,   6'd0,  1'b0, NO_FRAME},
        '{FN_READ, 6'd32, 1'b1, NO_FRAME},
        '{FN_TICK, 6'd0,  1'b0, NO_FRAME},
        '{FN_READ, 6'd32, 1'b1, NO_FRAME},
        '{FN_TICK, 6'd63, 1'b0, NO_FRAME},
        '{FN_READ, 6'd0,  1'b1, '{8'd0, 5'd0, 9'd3, 1'b0, 1'b1}},
        '{FN_READ, 6'd5,  1'b1, NO_FRAME},
        '{FN_D1,   6'd0,  1'b0, NO_FRAME},
        '{FN_D0,   6'd0,  1'b0, NO_FRAME},
        '{FN_D0,   6'd0,  1'b0, NO_FRAME},
        '{FN_D1,   6'd0,  1'b0, NO_FRAME},
        '{FN_TICK, 6'd0,  1'b0, NO_FRAME},
        '{FN_TICK, 6'd0,  1'b0, NO_FRAME},
        '{FN_READ, 6'd63, 1'b1, '{8'd9, 5'd0, 9'd4, 1'b1, 1'b1}},
        '{FN_D0,   6'd0,  1'b0, NO_FRAME},
        '{FN_D1,   6'd0,  1'b0, NO_FRAME},
        '{FN_TICK, 6'd0,  1'b0, NO_FRAME},
        '{FN_TICK, 6'd0,  1'b0, NO_FRAME},
        '{FN_READ, 6'd1,  1'b0, NO_FRAME},
        '{FN_D1,   6'd0,  1'b0, NO_FRAME},
        '{FN_READ, 6'd32, 1'b1, NO_FRAME}
    };

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func = FN_D0;
    logic [MAXB_W-1:0]    max_bytes = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           data_byte;
    logic [IDX_W-1:0]     byte_index;
    logic [BC_W-1:0]      bit_count;
    logic                 data_valid;
    logic                 last;

    logic [7:0]           frame_buf [DEPTH_BYTES_DEF];
    int unsigned          frame_bits;
    logic [TIMEOUT_W-1:0] idle_count;
    logic [TIMEOUT_W-1:0] timeout_val;

    out_rec_t expected_out [$];
    logic     row_typed = 1'b0;
    out_rec_t row_exp = NO_FRAME;
    int       items_taken = 0;
    int       results_seen = 0;
    int       errors = 0;
    int       cycles = 0;
    int       burst_left = 0;
    bit       gaps_on = 1'b0;
    int       stall_mode = 0;
    int       stall_cnt = 0;
    int       settings_used = 0;

    wiegand_frame_receiver_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .max_bytes   (max_bytes),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .bit_count   (bit_count),
        .data_valid  (data_valid),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic predict_item(input func_t f, input logic [MAXB_W-1:0] mb,
                                output out_rec_t res [RESULT_CAP], output int n);
        int unsigned pos;
        int unsigned cnt;
        n = 0;
        pos = frame_bits / BITS_PER_BYTE;
        case (f)
            FN_D0, FN_D1:
            begin
                if (pos < DEPTH_BYTES_DEF)
                begin
                    frame_buf[pos] = {frame_buf[pos][6:0], f == FN_D1};
                    frame_bits++;
                end
                idle_count = '0;
            end
            FN_TICK:
            begin
                if (idle_count != {TIMEOUT_W{1'b1}})
                    idle_count++;
            end
            default:
            begin
                if (!(frame_bits > 0 && idle_count > timeout_val))
                begin
                    res[0] = NO_FRAME;
                    n = 1;
                end
                else
                begin
                    cnt = pos + 1;
                    if (cnt > mb)
                        cnt = mb;
                    if (cnt > DEPTH_BYTES_DEF)
                        cnt = DEPTH_BYTES_DEF;
                    if (cnt > RESULT_CAP)
                        cnt = RESULT_CAP;
                    if (cnt == 0)
                    begin
                        res[0] = '{8'd0, 5'd0, frame_bits[BC_W-1:0], 1'b0, 1'b1};
                        n = 1;
                    end
                    else
                    begin
                        for (int k = 0; k < cnt; k++)
                            res[k] = '{frame_buf[k], k[IDX_W-1:0], frame_bits[BC_W-1:0],
                                       1'b1, k + 1 == cnt};
                        n = cnt;
                    end
                    foreach (frame_buf[i])
                        frame_buf[i] = '0;
                    frame_bits = 0;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_rec_t want;
        out_rec_t res [RESULT_CAP];
        int n;
        if (!rst_n)
        begin
            foreach (frame_buf[i])
                frame_buf[i] = '0;
            frame_bits = 0;
            idle_count = '0;
            timeout_val = TIMEOUT_RESET;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_out.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none actual byte %0d index %0d bits %0d",
                             $time, data_byte, byte_index, bit_count);
                end
                else
                begin
                    want = expected_out.pop_front();
                    check_field("data_byte", want.dbyte, data_byte);
                    check_field("byte_index", want.idx, byte_index);
                    check_field("bit_count", want.bits, bit_count);
                    check_field("data_valid", want.dv, data_valid);
                    check_field("last", want.last, last);
                end
            end
            if (cfg_wr_en)
                timeout_val = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                predict_item(func_t'(func), max_bytes, res, n);
                if (row_typed)
                    expected_out.push_back(row_exp);
                else
                    for (int k = 0; k < n; k++)
                        expected_out.push_back(res[k]);
                items_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout with %0d items still expected", $time, expected_out.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        stall_cnt++;
        if (stall_cnt % 64 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic send_item(input func_t f, input logic [MAXB_W-1:0] mb,
                             input logic typed, input out_rec_t e);
        int target;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        target = items_taken + 1;
        in_valid <= 1'b1;
        func <= f;
        max_bytes <= mb;
        row_typed = typed;
        row_exp = e;
        do @(negedge clk); while (items_taken < target);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_out.size() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic read_frame(input int nbits, input int nticks, input logic [MAXB_W-1:0] mb);
        for (int i = 0; i < nbits; i++)
            send_item($urandom_range(0, 1) ? FN_D1 : FN_D0, MAXB_W'($urandom_range(0, 63)),
                      1'b0, NO_FRAME);
        repeat (nticks)
            send_item(FN_TICK, MAXB_W'($urandom_range(0, 63)), 1'b0, NO_FRAME);
        send_item(FN_READ, mb, 1'b0, NO_FRAME);
    endtask

    initial
    begin
        int unsigned tmo_list [5];
        int unsigned tmo;
        int nb;
        int nt;
        int top;
        int r;
        int s_items;
        logic [MAXB_W-1:0] mb;

        tmo_list = '{1, 3, $urandom_range(4, 8), 24'hFFFFFF, 2};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_timeout(24'd1);
        foreach (PLAN[i])
            send_item(PLAN[i].f, PLAN[i].mb, PLAN[i].typed, PLAN[i].exp);

        for (int p = 0; p < 5; p++)
        begin
            tmo = tmo_list[p];
            write_timeout(tmo[TIMEOUT_W-1:0]);
            gaps_on = (p % 2 == 0);
            s_items = items_taken;
            while (items_taken - s_items < 14)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    send_item(func_t'($urandom_range(0, 3)), MAXB_W'($urandom_range(0, 63)),
                              1'b0, NO_FRAME);
                end
                else
                begin
                    r = $urandom_range(0, 9);
                    nb = (r < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
                    if (tmo > 8)
                        nt = $urandom_range(0, 5);
                    else if ($urandom_range(0, 5) == 0)
                        nt = $urandom_range(0, tmo);
                    else
                        nt = tmo + 1 + $urandom_range(0, 2);
                    top = nb / 8 + 1;
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        mb = MAXB_W'($urandom_range(top, 63));
                    else if (r < 8)
                        mb = MAXB_W'($urandom_range(0, 63));
                    else
                        mb = MAXB_W'($urandom_range(0, top));
                    read_frame(nb, nt, mb);
                    if ($urandom_range(0, 7) == 0)
                        send_item(FN_READ, MAXB_W'($urandom_range(0, 63)), 1'b0, NO_FRAME);
                end
            end
        end

        drain();
        $display("Run covered %0d input items and %0d result items under %0d timeout settings",
                 items_taken, results_seen, settings_used);
        $display("including multi-byte frames, zero-byte reads and reads of incomplete frames");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
